>>> rtl/argsplit_pkg.sv
package argsplit_pkg;

    // Result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_FULL = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    // Most results one input byte can cause, and result queue sizing
    localparam int MAX_RES = 3;
    localparam int Q_DEPTH = 4;
    localparam int PTR_W   = 2;
    localparam int CNT_W   = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_value;
        logic [7:0] arg_index;
        logic       truncated;
        logic       last;
    } res_t;

    // Results produced by one step, item[0] first
    typedef struct packed {
        logic [1:0]              count;
        res_t [MAX_RES-1:0]      item;
    } push_t;

endpackage

>>> rtl/shell_style_argument_splitter_core.sv
// Splits a command-line byte stream into arguments.
// Input channel (s_*): one byte per transfer in s_tdata; s_tlast high marks
// the end of the line, in which case the byte is ignored.
// Output channel (m_*): one result per transfer; m_tuser gives the kind
// (argument character, argument end, list full, line done), m_tlast marks
// the final result caused by one input byte. A byte may cause zero to three
// results.
// Configuration: arg_limit_we writes arg_limit_wdata as the most arguments
// kept per line; change it only while the block is idle.
// A byte goes from the input register through one pass of decode logic into
// the result queue. Throughput: one byte per cycle while each byte yields at
// most one result and m_tready stays high; otherwise the output drains one
// result per cycle and sets the pace.
// The four-entry result queue accepts a byte's results only when three
// entries are free, so a stalled receiver fills the queue and then drops
// s_tready; nothing is lost.
// Reset clears the line state and the queue and sets the limit to 255.
module shell_style_argument_splitter_core #(
    parameter int MAX_ARG_LEN = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,         // [7:0] line_byte
    input  logic        s_tlast,         // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,         // [7:0] char_value, [15:8] arg_index,
                                         // [16] truncated, [23:17] zero
    output logic [1:0]  m_tuser,         // [1:0] kind
    output logic        m_tlast,         // last
    input  logic        arg_limit_we,
    input  logic [7:0]  arg_limit_wdata
);

    logic               in_vld_reg;
    logic [7:0]         in_byte_reg;
    logic               in_eol_reg;
    logic               step, room, pop;
    argsplit_pkg::push_t push;
    argsplit_pkg::res_t  head;

    assign step     = in_vld_reg && room;
    assign s_tready = !in_vld_reg || step;
    assign pop      = m_tvalid && m_tready;

    // Hold the input register valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    // Capture the byte on each input transfer
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eol_reg  <= s_tlast;
        end
    end

    argsplit_decode #(
        .MAX_ARG_LEN (MAX_ARG_LEN)
    ) u_decode (
        .clk             (clk),
        .rst_n           (rst_n),
        .arg_limit_we    (arg_limit_we),
        .arg_limit_wdata (arg_limit_wdata),
        .step            (step),
        .line_byte       (in_byte_reg),
        .end_of_line     (in_eol_reg),
        .push            (push)
    );

    argsplit_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .room       (room),
        .head_valid (m_tvalid),
        .head       (head)
    );

    // Pack the head result onto the output channel
    assign m_tdata = {7'b0, head.truncated, head.arg_index, head.char_value};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

>>> rtl/argsplit_decode.sv
module argsplit_decode #(
    parameter int MAX_ARG_LEN = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 arg_limit_we,
    input  logic [7:0]           arg_limit_wdata,
    input  logic                 step,
    input  logic [7:0]           line_byte,
    input  logic                 end_of_line,
    output argsplit_pkg::push_t  push
);

    localparam int LEN_W = $clog2(MAX_ARG_LEN);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ARG_LEN - 1);

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_SINGLE = 2'd1;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

    localparam logic [2:0] ESC_NONE   = 3'd0;
    localparam logic [2:0] ESC_BSLASH = 3'd1;
    localparam logic [2:0] ESC_OCT1   = 3'd2;
    localparam logic [2:0] ESC_OCT2   = 3'd3;
    localparam logic [2:0] ESC_CARET  = 3'd4;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_DEL    = 8'h7f;
    localparam logic [7:0] CTRL_MASK = 8'h1f;

    logic [7:0]       arg_limit_reg;
    logic             in_arg_reg, in_arg_next;
    logic [1:0]       quote_reg, quote_next;
    logic [2:0]       esc_reg, esc_next;
    logic [7:0]       oct_reg, oct_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic             disc_reg, disc_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;

    logic       is_oct, is_blank, is_letter;
    logic [7:0] oct_shift, quote_char;
    logic       go, skip, put_a, put_b, end_arg;
    logic [7:0] val_a;
    logic [1:0] n;

    // Backslash escape letters
    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] v;
        case (c)
            8'h62:   v = 8'h08;
            8'h66:   v = 8'h0c;
            8'h6e:   v = 8'h0a;
            8'h72:   v = 8'h0d;
            8'h74:   v = 8'h09;
            8'h76:   v = 8'h0b;
            default: v = c;
        endcase
        return v;
    endfunction

    assign is_oct    = (line_byte[7:3] == 5'b00110);
    assign is_blank  = (line_byte == CH_SPACE) || (line_byte == CH_TAB);
    assign is_letter = ((line_byte >= 8'h41) && (line_byte <= 8'h5f))
                    || ((line_byte >= 8'h61) && (line_byte <= 8'h7a));
    assign oct_shift = {oct_reg[4:0], line_byte[2:0]};
    assign quote_char = (quote_reg == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

    // Work out the new line state and the results of one byte
    always_comb
    begin
        in_arg_next = in_arg_reg;
        quote_next  = quote_reg;
        esc_next    = esc_reg;
        oct_next    = oct_reg;
        cnt_next    = cnt_reg;
        disc_next   = disc_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        push        = '0;
        n           = 2'd0;
        go          = 1'b0;
        skip        = 1'b0;
        put_a       = 1'b0;
        put_b       = 1'b0;
        end_arg     = 1'b0;
        val_a       = 8'h00;

        // Resolve a pending escape
        if (step && !end_of_line && !disc_reg)
        begin
            go = 1'b1;
            case (esc_reg) inside
                ESC_NONE:
                begin
                end
                ESC_BSLASH:
                begin
                    go = 1'b0;
                    if (is_oct)
                    begin
                        oct_next = {5'b0, line_byte[2:0]};
                        esc_next = ESC_OCT1;
                    end
                    else
                    begin
                        put_a    = 1'b1;
                        val_a    = esc_map(line_byte);
                        esc_next = ESC_NONE;
                    end
                end
                ESC_OCT1, ESC_OCT2:
                begin
                    if (is_oct)
                    begin
                        go = 1'b0;
                        if (esc_reg == ESC_OCT2)
                        begin
                            put_a    = 1'b1;
                            val_a    = oct_shift;
                            oct_next = 8'h00;
                            esc_next = ESC_NONE;
                        end
                        else
                        begin
                            oct_next = oct_shift;
                            esc_next = ESC_OCT2;
                        end
                    end
                    else
                    begin
                        put_a    = 1'b1;
                        val_a    = oct_reg;
                        oct_next = 8'h00;
                        esc_next = ESC_NONE;
                    end
                end
                ESC_CARET:
                begin
                    esc_next = ESC_NONE;
                    put_a    = 1'b1;
                    if (line_byte == CH_QMARK)
                    begin
                        val_a = CH_DEL;
                        go    = 1'b0;
                    end
                    else if (is_letter)
                    begin
                        val_a = line_byte & CTRL_MASK;
                        go    = 1'b0;
                    end
                    else
                    begin
                        val_a = CH_CARET;
                    end
                end
                default:
                begin
                    esc_next = ESC_NONE;
                end
            endcase
        end

        // Flush a pending escape and close the argument at end of line
        if (step && end_of_line && !disc_reg && in_arg_reg)
        begin
            end_arg = 1'b1;
            case (esc_reg) inside
                ESC_BSLASH:
                begin
                    put_a = 1'b1;
                    val_a = CH_BSLASH;
                end
                ESC_OCT1, ESC_OCT2:
                begin
                    put_a = 1'b1;
                    val_a = oct_reg;
                end
                ESC_CARET:
                begin
                    put_a = 1'b1;
                    val_a = CH_CARET;
                end
                default:
                begin
                end
            endcase
            esc_next = ESC_NONE;
        end

        // Store the escape character, or mark the argument cut short
        if (put_a)
        begin
            if (len_next < LEN_MAX)
            begin
                push.item[n] = '{argsplit_pkg::KIND_CHAR, val_a, cnt_next, 1'b0, 1'b0};
                n = n + 2'd1;
                len_next = len_next + LEN_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        // Handle the byte itself
        if (go)
        begin
            if (!in_arg_next)
            begin
                if (is_blank)
                begin
                    skip = 1'b1;
                end
                else if (cnt_next >= arg_limit_reg)
                begin
                    push.item[n] = '{argsplit_pkg::KIND_FULL, 8'h00, cnt_next, 1'b0, 1'b0};
                    n = n + 2'd1;
                    disc_next = 1'b1;
                    skip = 1'b1;
                end
                else
                begin
                    in_arg_next = 1'b1;
                    quote_next  = QUOTE_NONE;
                    len_next    = '0;
                    ovf_next    = 1'b0;
                end
            end
            if (!skip)
            begin
                if (quote_next != QUOTE_NONE)
                begin
                    if (line_byte == quote_char)
                        quote_next = QUOTE_NONE;
                    else if (line_byte == CH_BSLASH)
                        esc_next = ESC_BSLASH;
                    else if (line_byte == CH_CARET)
                        esc_next = ESC_CARET;
                    else
                        put_b = 1'b1;
                end
                else if (line_byte == CH_DQUOTE)
                    quote_next = QUOTE_DOUBLE;
                else if (line_byte == CH_SQUOTE)
                    quote_next = QUOTE_SINGLE;
                else if (is_blank)
                    end_arg = 1'b1;
                else
                    put_b = 1'b1;
            end
        end

        // Store the plain byte
        if (put_b)
        begin
            if (len_next < LEN_MAX)
            begin
                push.item[n] = '{argsplit_pkg::KIND_CHAR, line_byte, cnt_next, 1'b0, 1'b0};
                n = n + 2'd1;
                len_next = len_next + LEN_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        // Close the argument
        if (end_arg)
        begin
            push.item[n] = '{argsplit_pkg::KIND_END, 8'h00, cnt_next, ovf_next, 1'b0};
            n = n + 2'd1;
            cnt_next    = cnt_next + 8'd1;
            in_arg_next = 1'b0;
            quote_next  = QUOTE_NONE;
            len_next    = '0;
            ovf_next    = 1'b0;
        end

        // Report the count and clear the line
        if (step && end_of_line)
        begin
            push.item[n] = '{argsplit_pkg::KIND_DONE, 8'h00, cnt_next, 1'b0, 1'b0};
            n = n + 2'd1;
            in_arg_next = 1'b0;
            quote_next  = QUOTE_NONE;
            esc_next    = ESC_NONE;
            oct_next    = 8'h00;
            cnt_next    = 8'h00;
            disc_next   = 1'b0;
            len_next    = '0;
            ovf_next    = 1'b0;
        end

        // Mark the final result of the byte
        if (n != 2'd0)
            push.item[n - 2'd1].last = 1'b1;
        push.count = n;
    end

    // Hold the argument limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            arg_limit_reg <= 8'hff;
        else if (arg_limit_we)
            arg_limit_reg <= arg_limit_wdata;
    end

    // Advance the line state on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_arg_reg <= 1'b0;
            quote_reg  <= QUOTE_NONE;
            esc_reg    <= ESC_NONE;
            oct_reg    <= 8'h00;
            cnt_reg    <= 8'h00;
            disc_reg   <= 1'b0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (step)
        begin
            in_arg_reg <= in_arg_next;
            quote_reg  <= quote_next;
            esc_reg    <= esc_next;
            oct_reg    <= oct_next;
            cnt_reg    <= cnt_next;
            disc_reg   <= disc_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

>>> rtl/argsplit_queue.sv
module argsplit_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  argsplit_pkg::push_t  push,
    input  logic                 pop,
    output logic                 room,
    output logic                 head_valid,
    output argsplit_pkg::res_t   head
);

    argsplit_pkg::res_t mem [argsplit_pkg::Q_DEPTH];

    logic [argsplit_pkg::PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [argsplit_pkg::CNT_W-1:0] count_reg, count_after_pop;

    assign count_after_pop = count_reg - argsplit_pkg::CNT_W'(pop);
    assign room = count_after_pop
               <= argsplit_pkg::CNT_W'(argsplit_pkg::Q_DEPTH - argsplit_pkg::MAX_RES);
    assign head_valid = (count_reg != '0);
    assign head = mem[rd_ptr_reg];

    // Write the results of one step in order
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < argsplit_pkg::MAX_RES; i++)
        begin
            if (2'(i) < push.count)
                mem[wr_ptr_reg + argsplit_pkg::PTR_W'(i)] <= push.item[i];
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + argsplit_pkg::PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + argsplit_pkg::PTR_W'(pop);
            count_reg  <= count_after_pop + argsplit_pkg::CNT_W'(push.count);
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

    // Short argument buffer so that over-length arguments stay cheap to reach
    localparam int ARG_LEN_MAX   = 16;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;

    // Escape decoder phases and open-quote modes
    localparam logic [2:0] ESC_NONE  = 3'd0;
    localparam logic [2:0] ESC_SLASH = 3'd1;
    localparam logic [2:0] ESC_OCT1  = 3'd2;
    localparam logic [2:0] ESC_OCT2  = 3'd3;
    localparam logic [2:0] ESC_CARET = 3'd4;

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_SINGLE = 2'd1;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CTRL_MASK = 8'o37;
    localparam logic [47:0] CTRL_LETTERS = "bfnrtv";

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;         // [7:0] line_byte
    logic        s_tlast = 1'b0;          // end_of_line
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;                 // [7:0] char_value, [15:8] arg_index,
                                          // [16] truncated, [23:17] zero
    logic [1:0]  m_tuser;                 // [1:0] kind
    logic        m_tlast;                 // last
    logic        arg_limit_we = 1'b0;
    logic [7:0]  arg_limit_wdata = 8'h00;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;
    int n_errors = 0;
    int quiet_cycles = 0;

    // Tokenizer state mirrored on the testbench side
    argsplit_pkg::res_t expected_tokens[$];
    argsplit_pkg::res_t step_buf[argsplit_pkg::MAX_RES];
    int         step_count;
    logic [7:0] tok_limit;
    logic       tok_in_arg;
    logic [1:0] tok_quote;
    logic [2:0] tok_escape;
    logic [7:0] tok_octal;
    logic [7:0] tok_count;
    logic       tok_discard;
    int         tok_length;
    logic       tok_overflow;

    shell_style_argument_splitter_core #(
        .MAX_ARG_LEN(ARG_LEN_MAX)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .arg_limit_we(arg_limit_we),
        .arg_limit_wdata(arg_limit_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Tokenizer prediction
    // ---------------------------------------------------------------

    function automatic void note_result(logic [1:0] kind, logic [7:0] ch, logic trunc);
        if (step_count < argsplit_pkg::MAX_RES)
        begin
            step_buf[step_count].kind       = kind;
            step_buf[step_count].char_value = ch;
            step_buf[step_count].arg_index  = tok_count;
            step_buf[step_count].truncated  = trunc;
            step_buf[step_count].last       = 1'b0;
            step_count++;
        end
    endfunction

    // Keep a byte unless the argument buffer is already full
    function automatic void keep_char(logic [7:0] c);
        if (tok_length < ARG_LEN_MAX - 1)
        begin
            note_result(argsplit_pkg::KIND_CHAR, c, 1'b0);
            tok_length++;
        end
        else
            tok_overflow = 1'b1;
    endfunction

    function automatic void close_argument();
        note_result(argsplit_pkg::KIND_END, 8'h00, tok_overflow);
        tok_count    = tok_count + 8'd1;
        tok_in_arg   = 1'b0;
        tok_quote    = QUOTE_NONE;
        tok_length   = 0;
        tok_overflow = 1'b0;
    endfunction

    function automatic void clear_line();
        tok_in_arg   = 1'b0;
        tok_quote    = QUOTE_NONE;
        tok_escape   = ESC_NONE;
        tok_octal    = 8'h00;
        tok_count    = 8'h00;
        tok_discard  = 1'b0;
        tok_length   = 0;
        tok_overflow = 1'b0;
    endfunction

    function automatic void feed_byte(logic [7:0] c);
        logic octal;
        octal = (c >= CH_ZERO) && (c <= CH_ZERO + 8'd7);
        if (tok_discard)
            return;

        // Finish any escape in progress
        if (tok_escape == ESC_SLASH)
        begin
            tok_escape = ESC_NONE;
            if (octal)
            begin
                tok_octal  = {5'b0, c[2:0]};
                tok_escape = ESC_OCT1;
                return;
            end
            case (c)
                "b":     keep_char(8'h08);
                "f":     keep_char(8'h0C);
                "n":     keep_char(8'h0A);
                "r":     keep_char(8'h0D);
                "t":     keep_char(8'h09);
                "v":     keep_char(8'h0B);
                default: keep_char(c);
            endcase
            return;
        end
        if (tok_escape == ESC_OCT1 || tok_escape == ESC_OCT2)
        begin
            if (octal)
            begin
                tok_octal = {tok_octal[4:0], c[2:0]};
                if (tok_escape == ESC_OCT2)
                begin
                    keep_char(tok_octal);
                    tok_octal  = 8'h00;
                    tok_escape = ESC_NONE;
                end
                else
                    tok_escape = ESC_OCT2;
                return;
            end
            // Run cut short: flush the value, then treat the byte normally
            keep_char(tok_octal);
            tok_octal  = 8'h00;
            tok_escape = ESC_NONE;
        end
        else if (tok_escape == ESC_CARET)
        begin
            tok_escape = ESC_NONE;
            if (c == CH_QMARK)
            begin
                keep_char(CH_DEL);
                return;
            end
            if ((c >= 8'h41 && c <= 8'h5F) || (c >= 8'h61 && c <= 8'h7A))
            begin
                keep_char(c & CTRL_MASK);
                return;
            end
            keep_char(CH_CARET);
        end

        // Start a new argument, or stop the line when the list is full
        if (!tok_in_arg)
        begin
            if (c == CH_SPACE || c == CH_TAB)
                return;
            if (tok_count >= tok_limit)
            begin
                note_result(argsplit_pkg::KIND_FULL, 8'h00, 1'b0);
                tok_discard = 1'b1;
                return;
            end
            tok_in_arg   = 1'b1;
            tok_quote    = QUOTE_NONE;
            tok_length   = 0;
            tok_overflow = 1'b0;
        end

        if (tok_quote != QUOTE_NONE)
        begin
            if (c == ((tok_quote == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE))
                tok_quote = QUOTE_NONE;
            else if (c == CH_BSLASH)
                tok_escape = ESC_SLASH;
            else if (c == CH_CARET)
                tok_escape = ESC_CARET;
            else
                keep_char(c);
        end
        else if (c == CH_DQUOTE)
            tok_quote = QUOTE_DOUBLE;
        else if (c == CH_SQUOTE)
            tok_quote = QUOTE_SINGLE;
        else if (c == CH_SPACE || c == CH_TAB)
            close_argument();
        else
            keep_char(c);
    endfunction

    // Advance the tokenizer by one accepted item and queue its results
    function automatic void tokenize_byte(logic [7:0] b, logic eol);
        argsplit_pkg::res_t r;
        step_count = 0;
        if (eol)
        begin
            if (!tok_discard && tok_in_arg)
            begin
                case (tok_escape)
                    ESC_SLASH:          keep_char(CH_BSLASH);
                    ESC_OCT1, ESC_OCT2: keep_char(tok_octal);
                    ESC_CARET:          keep_char(CH_CARET);
                    default:            ;
                endcase
                tok_escape = ESC_NONE;
                close_argument();
            end
            note_result(argsplit_pkg::KIND_DONE, 8'h00, 1'b0);
            clear_line();
        end
        else
            feed_byte(b);
        for (int i = 0; i < step_count; i++)
        begin
            r = step_buf[i];
            r.last = (i == step_count - 1);
            expected_tokens.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // Result checking and watchdog
    // ---------------------------------------------------------------

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        argsplit_pkg::res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected result: kind %0d, data %h", m_tuser, m_tdata);
                n_errors++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_tuser));
                check_field("char_value", 32'(want.char_value), 32'(m_tdata[7:0]));
                check_field("arg_index", 32'(want.arg_index), 32'(m_tdata[15:8]));
                check_field("truncated", 32'(want.truncated), 32'(m_tdata[16]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // Stall the result side at random
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // End the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** shell_style_argument_splitter_core: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    task automatic send_line_byte(input logic [7:0] b, input logic eol);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eol;
        do
            @(posedge clk);
        while (!s_tready);
        tokenize_byte(b, eol);
        bytes_sent++;
    endtask

    // Drop valid, let every queued result drain, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_arg_limit(input logic [7:0] value);
        arg_limit_we    <= 1'b1;
        arg_limit_wdata <= value;
        @(posedge clk);
        arg_limit_we    <= 1'b0;
        tok_limit = value;
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] octal_digit();
        return 8'(CH_ZERO + $urandom_range(0, 7));
    endfunction

    // Mostly plain text, now and then any byte at all
    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5: return 8'(8'h61 + $urandom_range(0, 25));
            6, 7, 8:          return 8'(8'h41 + $urandom_range(0, 25));
            9, 10, 11:        return 8'(CH_ZERO + $urandom_range(0, 9));
            12, 13, 14:       return 8'($urandom_range(8'h80, 8'hFF));
            default:          return any_byte();
        endcase
    endfunction

    function automatic logic [7:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd2;
            3:       return 8'd3;
            4:       return 8'd255;
            default: return any_byte();
        endcase
    endfunction

    task automatic send_separator();
        send_line_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
    endtask

    task automatic send_escape();
        int k;
        k = $urandom_range(0, 5);
        send_line_byte((k < 3) ? CH_BSLASH : CH_CARET, 1'b0);
        case (k)
            0: send_line_byte(CTRL_LETTERS[8 * $urandom_range(0, 5) +: 8], 1'b0);
            1: repeat ($urandom_range(1, 3)) send_line_byte(octal_digit(), 1'b0);
            3: send_line_byte(CH_QMARK, 1'b0);
            4: send_line_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5F))
                                                   : 8'($urandom_range(8'h61, 8'h7A)), 1'b0);
            default: send_line_byte(any_byte(), 1'b0);
        endcase
    endtask

    // One argument: long, plain, quoted, quoted from mid-word, or quoted with a tail
    task automatic send_argument(input bit long_word);
        int style;
        logic [7:0] quote_char;
        style = $urandom_range(0, 3);
        if (long_word)
        begin
            repeat ($urandom_range(ARG_LEN_MAX - 2, ARG_LEN_MAX + 6))
                send_line_byte(text_byte(), 1'b0);
            return;
        end
        if (style == 0)
        begin
            repeat ($urandom_range(1, 6)) send_line_byte(text_byte(), 1'b0);
            return;
        end
        if (style == 2)
            repeat ($urandom_range(1, 3)) send_line_byte(text_byte(), 1'b0);
        quote_char = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        send_line_byte(quote_char, 1'b0);
        repeat ($urandom_range(0, 5))
        begin
            case ($urandom_range(0, 3))
                0, 1:    send_escape();
                2:       send_separator();
                default: send_line_byte(text_byte(), 1'b0);
            endcase
        end
        // Leave the quote open now and then
        if ($urandom_range(0, 9) != 0)
            send_line_byte(quote_char, 1'b0);
        if (style == 3)
            repeat ($urandom_range(1, 3)) send_line_byte(text_byte(), 1'b0);
    endtask

    task automatic send_random_line();
        int n_args;
        n_args = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
        repeat ($urandom_range(0, 1)) send_separator();
        for (int a = 0; a < n_args; a++)
        begin
            if (a != 0)
                repeat ($urandom_range(1, 2)) send_separator();
            send_argument($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 14) == 0)
                repeat ($urandom_range(1, 3)) send_line_byte(any_byte(), 1'b0);
            // Change the limit in the middle of a line
            if ($urandom_range(0, 24) == 0)
            begin
                wait_idle();
                set_arg_limit(pick_limit());
            end
        end
        // Hold an escape open into the end of the line
        case ($urandom_range(0, 7))
            0:
            begin
                send_line_byte(CH_DQUOTE, 1'b0);
                send_line_byte(CH_BSLASH, 1'b0);
            end
            1:
            begin
                send_line_byte(CH_SQUOTE, 1'b0);
                send_line_byte(CH_CARET, 1'b0);
            end
            2:
            begin
                send_line_byte(CH_DQUOTE, 1'b0);
                send_line_byte(CH_BSLASH, 1'b0);
                repeat ($urandom_range(1, 2)) send_line_byte(octal_digit(), 1'b0);
            end
            3:       send_separator();
            default: ;
        endcase
        send_line_byte(any_byte(), 1'b1);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Extreme bytes, empty quotes, mid-word quote, every escape form,
    // and a backslash left pending in an unclosed quote at end of line
    task automatic test_escapes();
        logic [7:0] line_bytes [27];
        line_bytes = '{8'h00, 8'hFF, CH_SPACE, CH_TAB, CH_SQUOTE, CH_SQUOTE, CH_SPACE,
                       "a", CH_DQUOTE, CH_BSLASH, "7", "7", "7", CH_BSLASH, "1", "x",
                       CH_CARET, CH_QMARK, CH_CARET, "Z", CH_CARET, "1",
                       CH_BSLASH, "n", CH_BSLASH, "q", CH_BSLASH};
        foreach (line_bytes[i])
            send_line_byte(line_bytes[i], 1'b0);
        send_line_byte(any_byte(), 1'b1);
        wait_idle();
    endtask

    task automatic test_random_lines(input int send_pct, input int recv_pct,
                                     input logic [7:0] first_limit, input int n_bytes);
        int stop_at;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        wait_idle();
        set_arg_limit(first_limit);
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            send_random_line();
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                set_arg_limit(pick_limit());
            end
        end
        wait_idle();
    endtask

    initial
    begin
        tok_limit = 8'd255;
        clear_line();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_escapes();
        test_random_lines(24, 81, 8'd255, 60);
        test_random_lines(81, 24, 8'd0, 60);
        test_random_lines(0, 0, 8'd1, 70);

        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("** shell_style_argument_splitter_core: PASSED **");
        else
            $display("** shell_style_argument_splitter_core: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
rtl/argsplit_pkg.sv
rtl/argsplit_decode.sv
rtl/argsplit_queue.sv
rtl/shell_style_argument_splitter_core.sv
dv/tb.sv
